@@ sv/sfhe_pkg.sv @@
`timescale 1ns / 1ps
// Package for the sample frame hex encoder: channel payload types, the frame
// record passed from framing to emitter, and CRC-16 and hex helpers. No dependencies.
package sfhe_pkg;

  localparam int unsigned PosWidth = 10;
  localparam logic [PosWidth-1:0] FrameLenReset = 10'd405;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [7:0] ChZ     = 8'h5A;

  typedef struct packed {
    logic [31:0] timestamp_ms;
    logic [15:0] sample_value;
  } sfhe_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } sfhe_out_t;

  typedef struct packed {
    logic [31:0] ts;
    logic [11:0] sample;
    logic [15:0] crc;
    logic        header;
    logic        trailer;
  } sfhe_rec_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = data[7-k] ^ c[15];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] a;
    a = {4'h0, nib} + ChZero;
    if (nib > 4'd9) begin
      a = a + 8'd7;
    end
    return a;
  endfunction

endpackage

@@ sv/sample_frame_hex_encoder_crc16_core.sv @@
`timescale 1ns / 1ps
// Sample frame hex encoder with CRC-16/XMODEM: each accepted sample yields one
// ASCII character per output transaction. A mid-frame sample yields 4 characters
// (three hex digits and a comma), the first sample of a frame adds 10 (header
// 'T', eight timestamp digits, 'S') and the last adds 6 (trailer 'X', four CRC
// digits, 'Z'), so 4 to 20 characters per sample. The emitter gives one character
// per cycle while char_ready is high. Two registered framing stages sit ahead of
// it, so the next samples are taken while characters are still going out; the first
// character comes out after the input, record and emitter registers. Depends on sfhe_pkg, sfhe_frame and sfhe_emit.
module sample_frame_hex_encoder_crc16_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  sfhe_pkg::sfhe_in_t  sample_data,
  output logic                char_valid,
  input  logic                char_ready,
  output sfhe_pkg::sfhe_out_t char_data,
  input  logic                cfg_write_en,
  input  logic [9:0]          cfg_write_data
);
  import sfhe_pkg::*;

  logic      rec_valid;
  logic      rec_take;
  sfhe_rec_t rec;

  sfhe_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample_data    (sample_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .rec_valid      (rec_valid),
    .rec            (rec),
    .rec_take       (rec_take)
  );

  sfhe_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .rec_valid  (rec_valid),
    .rec        (rec),
    .rec_take   (rec_take),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data)
  );

endmodule

@@ sv/sfhe_frame.sv @@
`timescale 1ns / 1ps
// Framing stages: input register with timestamp CRC, then frame position,
// running CRC and the frame record register. Depends on sfhe_pkg.
module sfhe_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  sfhe_pkg::sfhe_in_t   sample_data,
  input  logic                 cfg_write_en,
  input  logic [9:0]           cfg_write_data,
  output logic                 rec_valid,
  output sfhe_pkg::sfhe_rec_t  rec,
  input  logic                 rec_take
);
  import sfhe_pkg::*;

  logic                s1_valid;
  logic [31:0]         s1_ts;
  logic [15:0]         s1_sample;
  logic [15:0]         s1_ts_crc;
  logic [15:0]         ts_crc_next;

  logic [PosWidth-1:0] samples_per_frame;
  logic [PosWidth-1:0] position;
  logic [PosWidth-1:0] position_next;
  logic [15:0]         crc_value;
  logic [15:0]         crc_next;
  logic [15:0]         crc_base;
  logic                header;
  logic                trailer;
  logic                s2_load;

  assign ts_crc_next = crc_byte(crc_byte(crc_byte(crc_byte(16'h0000,
                         sample_data.timestamp_ms[31:24]), sample_data.timestamp_ms[23:16]),
                         sample_data.timestamp_ms[15:8]), sample_data.timestamp_ms[7:0]);

  assign s2_load      = s1_valid && (!rec_valid || rec_take);
  assign sample_ready = !s1_valid || s2_load;

  assign header        = (position == '0);
  assign crc_base      = header ? s1_ts_crc : crc_value;
  assign crc_next      = crc_byte(crc_byte(crc_base, s1_sample[15:8]), s1_sample[7:0]);
  assign position_next = position + 1'b1;
  assign trailer       = (position_next == samples_per_frame);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      rec_valid         <= 1'b0;
      position          <= '0;
      crc_value         <= '0;
      samples_per_frame <= FrameLenReset;
    end else begin
      if (cfg_write_en) begin
        samples_per_frame <= cfg_write_data;
      end
      if (sample_valid && sample_ready) begin
        s1_valid  <= 1'b1;
        s1_ts     <= sample_data.timestamp_ms;
        s1_sample <= sample_data.sample_value;
        s1_ts_crc <= ts_crc_next;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        rec_valid   <= 1'b1;
        rec.ts      <= s1_ts;
        rec.sample  <= s1_sample[11:0];
        rec.crc     <= crc_next;
        rec.header  <= header;
        rec.trailer <= trailer;
        crc_value   <= crc_next;
        position    <= trailer ? '0 : position_next;
      end else if (rec_take) begin
        rec_valid <= 1'b0;
      end
    end
  end

  a_trailer_rearm: assert property (@(posedge clk) disable iff (rst)
    s2_load && trailer |=> position == '0)
    else $error("position not cleared after trailer");

  a_position_step: assert property (@(posedge clk) disable iff (rst)
    s2_load && !trailer |=> position == $past(position) + 1'b1)
    else $error("position did not advance by one");

  a_rec_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_take |=> rec_valid && $stable(rec))
    else $error("frame record changed before it was taken");

endmodule

@@ sv/sfhe_emit.sv @@
`timescale 1ns / 1ps
// Character emitter: holds one frame record and steps through its characters,
// one per output transaction. Depends on sfhe_pkg.
module sfhe_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  input  sfhe_pkg::sfhe_rec_t  rec,
  output logic                 rec_take,
  output logic                 char_valid,
  input  logic                 char_ready,
  output sfhe_pkg::sfhe_out_t  char_data
);
  import sfhe_pkg::*;

  localparam logic [4:0] SlotHead    = 5'd0;
  localparam logic [4:0] SlotTsFirst = 5'd1;
  localparam logic [4:0] SlotTsLast  = 5'd8;
  localparam logic [4:0] SlotSep     = 5'd9;
  localparam logic [4:0] SlotSample  = 5'd10;
  localparam logic [4:0] SlotSmpLast = 5'd12;
  localparam logic [4:0] SlotComma   = 5'd13;
  localparam logic [4:0] SlotTrail   = 5'd14;
  localparam logic [4:0] SlotCrc     = 5'd15;
  localparam logic [4:0] SlotCrcLast = 5'd18;
  localparam logic [4:0] SlotEnd     = 5'd19;

  logic       busy;
  sfhe_rec_t  rec_w;
  logic [4:0] idx;
  logic       last;
  logic [3:0] ts_nib;
  logic [3:0] smp_nib;
  logic [3:0] crc_nib;
  logic [2:0] ts_sel;
  logic [1:0] smp_off;
  logic [1:0] crc_off;
  logic [7:0] ch;

  assign last     = rec_w.trailer ? (idx == SlotEnd) : (idx == SlotComma);
  assign rec_take = rec_valid && (!busy || (char_ready && last));

  assign ts_sel  = 3'(SlotTsLast - idx);
  assign smp_off = 2'(SlotSmpLast - idx);
  assign crc_off = 2'(SlotCrcLast - idx);
  assign ts_nib  = rec_w.ts[{ts_sel, 2'b00} +: 4];
  assign smp_nib = rec_w.sample[{smp_off, 2'b00} +: 4];
  assign crc_nib = rec_w.crc[{crc_off, 2'b00} +: 4];

  always_comb begin
    case (idx) inside
      SlotHead:                  ch = ChT;
      [SlotTsFirst:SlotTsLast]:  ch = hex_char(ts_nib);
      SlotSep:                   ch = ChS;
      [SlotSample:SlotSmpLast]:  ch = hex_char(smp_nib);
      SlotComma:                 ch = ChComma;
      SlotTrail:                 ch = ChX;
      [SlotCrc:SlotCrcLast]:     ch = hex_char(crc_nib);
      default:                   ch = ChZ;
    endcase
  end

  assign char_valid         = busy;
  assign char_data.out_char = ch;
  assign char_data.run_last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= SlotHead;
    end else if (rec_take) begin
      busy  <= 1'b1;
      rec_w <= rec;
      idx   <= rec.header ? SlotHead : SlotSample;
    end else if (busy && char_ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= SlotEnd && (rec_w.trailer || idx <= SlotComma))
    else $error("character slot beyond end of record");

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    rec_take |=> busy && (idx == SlotHead || idx == SlotSample))
    else $error("record loaded at wrong slot");

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    rec_take |-> rec_valid)
    else $error("record taken while none valid");

endmodule
